>>> rtl/ssi_pkg.sv
// Shared types and constants for the sorted set insert core.
`default_nettype none

package ssi_pkg;

  // Number of cells in the chain, and the width of a count from 0 to CAPACITY
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Result status codes
  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_ELEMENT   = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } fsm_t;

  // Operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE
  } cell_op_t;

  // Broadcast control word for the chain
  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/sorted_set_insert_core.sv
// Top level of the sorted set insert core: cell chain, sequencer and result register.
//
//  channel | direction | accepted when          | payload
//  in_     | slave     | in_tvalid & in_tready  | tuser: cmd, tdata: value
//  out_    | master    | out_tvalid & out_tready| tuser: status, tdata: element,
//          |           |                        | occupancy, tlast: last
//
// In an insert the whole chain compares and shifts at the accepting edge,
// and its result word sits in the output register from the next cycle.
// In a read out of n values the chain rotates one cell per cycle while the output is free,
// toward cell 0, which feeds the output register; no input word is taken meanwhile.
// Reset clears the stored count and the sequencer; cell contents need no clearing.
// A stalled output holds its word, and the chain and the input wait with it.
`default_nettype none

module sorted_set_insert_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] value
  input  wire  [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [31:0] element, [36:32] occupancy, [39:37] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast
);
  import ssi_pkg::*;

  fsm_t                state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic signed [31:0]  out_element_r, out_element_nxt;
  logic                out_last_r, out_last_nxt;
  logic [CNT_W-1:0]    out_occ_r, out_occ_nxt;

  cell_ctl_t           ctl;
  logic                out_free;
  logic                in_fire;
  logic                dup;
  logic                full;

  logic signed [31:0]  cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_below;
  logic [CAPACITY-1:0] cell_match;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == FSM_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign dup       = |cell_match;
  assign full      = (count_r == CNT_W'(CAPACITY));

  // Build the chain
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic               prev_below;
      logic signed [31:0] prev_entry;
      logic signed [31:0] next_entry;

      if (g == 0) begin : g_first
        assign prev_below = 1'b1;
        assign prev_entry = ctl.value;
      end else begin : g_inner
        assign prev_below = cell_below[g-1];
        assign prev_entry = cell_entry[g-1];
      end

      if (g == CAPACITY - 1) begin : g_end
        assign next_entry = cell_entry[0];
      end else begin : g_mid
        assign next_entry = cell_entry[g+1];
      end

      ssi_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .valid      (CNT_W'(g) < count_r),
        .tail       ((CNT_W'(g) + CNT_W'(1)) == count_r),
        .prev_below (prev_below),
        .prev_entry (prev_entry),
        .next_entry (next_entry),
        .head_entry (cell_entry[0]),
        .entry      (cell_entry[g]),
        .below      (cell_below[g]),
        .match      (cell_match[g])
      );
    end
  endgenerate

  // Sequencer, chain control and result word
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    rd_idx_nxt      = rd_idx_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    out_occ_nxt     = out_occ_r;
    ctl.op          = OP_HOLD;
    ctl.value       = $signed(in_tdata);

    unique case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0]) begin
            if (count_r == '0) begin
              out_valid_nxt   = 1'b1;
              out_status_nxt  = STAT_EMPTY;
              out_element_nxt = '0;
              out_last_nxt    = 1'b1;
              out_occ_nxt     = count_r;
            end else begin
              state_nxt  = FSM_READ;
              rd_idx_nxt = '0;
            end
          end else begin
            out_valid_nxt   = 1'b1;
            out_element_nxt = '0;
            out_last_nxt    = 1'b1;
            priority if (dup) begin
              out_status_nxt = STAT_DUPLICATE;
              out_occ_nxt    = count_r;
            end else if (full) begin
              out_status_nxt = STAT_FULL;
              out_occ_nxt    = count_r;
            end else begin
              ctl.op         = OP_INSERT;
              count_nxt      = count_r + CNT_W'(1);
              out_status_nxt = STAT_INSERTED;
              out_occ_nxt    = count_r + CNT_W'(1);
            end
          end
        end
      end
      FSM_READ: begin
        if (out_free) begin
          ctl.op          = OP_ROTATE;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = STAT_ELEMENT;
          out_element_nxt = cell_entry[0];
          out_last_nxt    = (rd_idx_r + CNT_W'(1)) == count_r;
          out_occ_nxt     = count_r;
          rd_idx_nxt      = rd_idx_r + CNT_W'(1);
          if ((rd_idx_r + CNT_W'(1)) == count_r) begin
            state_nxt = FSM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(40 - 32 - CNT_W){1'b0}}, out_occ_r, out_element_r};

  // Ordering check over the occupied cells
  logic chain_sorted;
  always_comb begin
    chain_sorted = 1'b1;
    for (int k = 0; k < CAPACITY - 1; k++) begin
      if ((CNT_W'(k + 1) < count_r) && (cell_entry[k] >= cell_entry[k+1])) begin
        chain_sorted = 1'b0;
      end
    end
  end

  // Count never passes the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  // Occupied cells stay strictly ascending between read outs
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_IDLE) |-> chain_sorted)
    else $error("chain out of order");

  // A new value grows the count by one
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_tuser[0] && !dup && !full) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow count");

  // Read index stays below the count during read out
  a_read_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_READ) |-> (rd_idx_r < count_r))
    else $error("read index past stored count");

endmodule

`default_nettype wire

>>> rtl/ssi_cell.sv
// One storage cell of the sorted chain: compare, shift on insert, rotate on read.
`default_nettype none

module ssi_cell (
  input  wire                      clk,
  input  ssi_pkg::cell_ctl_t       ctl,
  input  wire                      valid,       // cell index below stored count
  input  wire                      tail,        // cell index equals stored count minus one
  input  wire                      prev_below,  // lower neighbor holds a smaller value
  input  wire  signed [31:0]       prev_entry,
  input  wire  signed [31:0]       next_entry,
  input  wire  signed [31:0]       head_entry,
  output logic signed [31:0]       entry,
  output logic                     below,
  output logic                     match
);
  import ssi_pkg::*;

  logic signed [31:0] entry_r;
  logic signed [31:0] entry_nxt;

  // Compare own entry with the broadcast value
  assign below = valid && (entry_r < ctl.value);
  assign match = valid && (entry_r == ctl.value);
  assign entry = entry_r;

  // Keep, take the new value, or take the neighbor's entry
  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.op)
      OP_INSERT: begin
        if (!below) begin
          entry_nxt = prev_below ? ctl.value : prev_entry;
        end
      end
      OP_ROTATE: begin
        entry_nxt = tail ? head_entry : next_entry;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the sorted set insert core, run against a model of the ordered set.
`timescale 1ns / 100ps

module testbench;
  import ssi_pkg::*;

  localparam logic CMD_INSERT   = 1'b0;
  localparam logic CMD_READ_OUT = 1'b1;

  localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

  localparam int RANDOM_WORDS = 400;
  localparam int HOLD_CYCLES  = 120;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_CYCLES = 40;

  // One expected result word
  typedef struct {
    logic [2:0]         status;
    logic signed [31:0] element;
    logic [6:0]         occupancy;
    logic               last;
  } set_result_t;

  // Model of the ordered set plus the queue of result words still owed by the core
  class sorted_set_scoreboard;
    logic signed [31:0] members [CAPACITY];
    int                 member_count;
    set_result_t        awaited [$];
    int                 failures;

    function new();
      member_count = 0;
      failures     = 0;
    endfunction

    function bit holds(logic signed [31:0] value);
      for (int k = 0; k < member_count; k++)
        if (members[k] == value) return 1'b1;
      return 1'b0;
    endfunction

    function void push_result(status_t status, logic signed [31:0] element, logic last);
      set_result_t word;
      word.status    = status;
      word.element   = element;
      word.occupancy = 7'(member_count);
      word.last      = last;
      awaited.push_back(word);
    endfunction

    // Update the set for an accepted input word and queue the words it causes
    function void note_word(logic cmd, logic signed [31:0] value);
      int pos;
      if (cmd == CMD_READ_OUT) begin
        if (member_count == 0) push_result(STAT_EMPTY, '0, 1'b1);
        for (int k = 0; k < member_count; k++)
          push_result(STAT_ELEMENT, members[k], k == member_count - 1);
        return;
      end
      // Find the first slot not smaller than the value
      pos = 0;
      while (pos < member_count && members[pos] < value) pos++;
      if (pos < member_count && members[pos] == value) begin
        push_result(STAT_DUPLICATE, '0, 1'b1);
      end else if (member_count >= CAPACITY) begin
        push_result(STAT_FULL, '0, 1'b1);
      end else begin
        for (int k = member_count; k > pos; k--) members[k] = members[k - 1];
        members[pos] = value;
        member_count++;
        push_result(STAT_INSERTED, '0, 1'b1);
      end
    endfunction

    // Compare one accepted result word with the oldest one owed
    function void check_word(logic [2:0] status, logic [39:0] data, logic last);
      set_result_t want;
      if (awaited.size() == 0) begin
        if (failures < REPORT_LIMIT)
          $display("unexpected result: status %0d element %0d occupancy %0d last %0b",
                   status, $signed(data[31:0]), data[38:32], last);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status || $signed(data[31:0]) !== want.element ||
          data[38:32] !== want.occupancy || data[39] !== 1'b0 || last !== want.last) begin
        if (failures < REPORT_LIMIT)
          $display({"mismatch: expected status %0d element %0d occupancy %0d last %0b, ",
                    "got status %0d element %0d occupancy %0d last %0b pad %0b"},
                   want.status, want.element, want.occupancy, want.last,
                   status, $signed(data[31:0]), data[38:32], last, data[39]);
        failures++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  bit hold_pending = 1'b0;
  bit calm         = 1'b0;

  sorted_set_scoreboard scoreboard = new();

  sorted_set_insert_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  // Offer one word, with an occasional gap ahead of it, and hold it until taken
  task automatic send_word(input logic cmd, input logic signed [31:0] value);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scoreboard.note_word(cmd, value);
  endtask

  // Stimulus
  initial begin
    logic signed [31:0] pick;
    int                 choice;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty read out, extremes, duplicates, a read out of the stored values
    send_word(CMD_READ_OUT, 32'h0);
    send_word(CMD_INSERT, 32'sd0);
    send_word(CMD_INSERT, VALUE_MIN);
    send_word(CMD_INSERT, VALUE_MAX);
    send_word(CMD_INSERT, -32'sd1);
    send_word(CMD_INSERT, 32'sd1);
    send_word(CMD_INSERT, 32'sd0);
    send_word(CMD_INSERT, VALUE_MIN);
    send_word(CMD_READ_OUT, 32'hffff_ffff);

    // Fill the store, then a new value and duplicates while full, then a full read out
    while (scoreboard.member_count < CAPACITY) send_word(CMD_INSERT, $urandom);
    do pick = $urandom; while (scoreboard.holds(pick));
    send_word(CMD_INSERT, pick);
    send_word(CMD_INSERT, VALUE_MIN);
    send_word(CMD_INSERT, VALUE_MAX);
    send_word(CMD_READ_OUT, $urandom);

    // Random mix of read outs, duplicates of stored values and new values
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) hold_pending = 1'b1;
      if (n == RANDOM_WORDS * 7 / 8) calm = 1'b1;
      choice = $urandom_range(0, 9);
      if (choice < 3)
        send_word(CMD_READ_OUT, $urandom);
      else if (choice < 7)
        send_word(CMD_INSERT,
                  scoreboard.members[$urandom_range(0, scoreboard.member_count - 1)]);
      else if (choice == 7)
        send_word(CMD_INSERT, int'($urandom_range(0, 64)) - 32);
      else
        send_word(CMD_INSERT, $urandom);
    end
    in_tvalid <= 1'b0;

    // Drain the owed words, then watch for strays
    while (scoreboard.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scoreboard.failures == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Result side: random stalls, one long hold-off to back the core up
  initial begin
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      scoreboard.check_word(out_tuser, out_tdata, out_tlast);
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/ssi_pkg.sv
rtl/ssi_cell.sv
rtl/sorted_set_insert_core.sv
sim/testbench.sv
